>>> hw/rtl/pgl_pkg.sv
package pgl_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [2:0] {
        OP_LOAD_NAME   = 3'd0,
        OP_STRIP_PIXEL = 3'd1,
        OP_STRIP_END   = 3'd2,
        OP_TEXT_START  = 3'd3,
        OP_TEXT_CHAR   = 3'd4
    } opcode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SPLIT_COLOR     = 3'd0,
        CFG_STRIP_HEIGHT    = 3'd1,
        CFG_SPACE_SIZE      = 3'd2,
        CFG_LETTER_DISTANCE = 3'd3,
        CFG_LINE_OFFSET     = 3'd4,
        CFG_SCALE           = 3'd5
    } cfg_index_t;

    // control characters in text
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_TAB     = 8'd9;

    // register reset values
    localparam logic [31:0] RST_SPLIT_COLOR     = 32'd0;
    localparam logic [7:0]  RST_STRIP_HEIGHT    = 8'd8;
    localparam logic [7:0]  RST_SPACE_SIZE      = 8'd4;
    localparam logic [7:0]  RST_LETTER_DISTANCE = 8'd1;
    localparam logic [7:0]  RST_LINE_OFFSET     = 8'd0;
    localparam logic [4:0]  RST_SCALE           = 5'd1;

    // scale limits and glyph width ceiling
    localparam logic [4:0]  SCALE_MIN = 5'd1;
    localparam logic [4:0]  SCALE_MAX = 5'd16;
    localparam logic [11:0] WIDTH_MAX = 12'd4095;

    // clamp to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/proportional_glyph_layout.sv
// Proportional bitmap-font layout engine. Feed the glyph names first (one
// load-name transaction per character), then the first row of the font strip
// left to right, one pixel per transaction, closed by a strip-end
// transaction. Text-start sets the pen; each text-char then returns one
// result: a source/destination rectangle when the character is a known glyph,
// and always the pen x after the character and the number of glyphs defined.
// Every transaction yields exactly one result. The block takes one
// transaction per clock cycle; a transaction passes through the input
// register, then the result register, and a result held by m_tready low
// stalls the input once both registers are full.
// The glyph table (start and width
// per code) is a memory read as the transaction is taken, with a bypass for
// a write in that same cycle; glyph valid bits live in flip-flops, so no
// clearing pass runs after reset.
module proportional_glyph_layout #(
    parameter int MAX_NAMES   = 128,
    parameter int STRIP_WIDTH = 4096,
    parameter int CHAR_CODES  = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration writes
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // char_code[7:0], pixel_rgba[39:8], start_x[55:40], start_y[71:56]
    input  logic [71:0]  s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // src_x[11:0], src_w[23:12], dest_x[39:24], dest_y[55:40], dest_w[71:56],
    // dest_h[83:72], pen_x[99:84], glyphs_defined[107:100], zero [111:108]
    output logic [111:0] m_tdata,
    // draw[0]
    output logic [0:0]   m_tuser
);

    localparam int NAME_CW = $clog2(MAX_NAMES + 1);
    localparam int NAME_AW = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
    localparam int COL_W   = $clog2(STRIP_WIDTH + 1);
    localparam int CHAR_AW = $clog2(CHAR_CODES);

    // configuration registers
    logic [31:0]        split_color_reg;
    logic [7:0]         strip_height_reg;
    logic [7:0]         space_size_reg;
    logic signed [7:0]  letter_distance_reg;
    logic signed [7:0]  line_offset_reg;
    logic [4:0]         scale_reg;

    // input stage
    logic               in_valid_reg;
    logic [2:0]         op_reg;
    logic [7:0]         ch_reg;
    logic [31:0]        pix_reg;
    logic signed [15:0] sx_reg;
    logic signed [15:0] sy_reg;

    // layout state
    logic [NAME_CW-1:0]    name_count_reg, name_count_next;
    logic [NAME_CW-1:0]    glyph_counter_reg, glyph_counter_next;
    logic [COL_W-1:0]      scan_column_reg, scan_column_next;
    logic [COL_W-1:0]      glyph_begin_reg, glyph_begin_next;
    logic [CHAR_CODES-1:0] known_reg;
    logic signed [15:0]    pen_x_reg, pen_x_next;
    logic signed [15:0]    pen_y_reg, pen_y_next;

    // name memory
    logic [7:0]         name_mem [MAX_NAMES];
    logic [7:0]         nrd_reg;
    logic               nbyp_reg;
    logic [7:0]         nbyp_data_reg;
    logic [7:0]         name_code;
    logic               name_we;
    logic               name_we_fire;
    logic [NAME_AW-1:0] name_waddr;
    logic [NAME_AW-1:0] name_raddr;
    logic [NAME_CW-1:0] gc_after;

    // glyph table memory: start[23:12], width[11:0]
    logic [23:0]        glyph_mem [CHAR_CODES];
    logic [23:0]        grd_reg;
    logic               gbyp_reg;
    logic [23:0]        gbyp_data_reg;
    logic [23:0]        g_entry;
    logic               glyph_we;
    logic               glyph_we_fire;
    logic [CHAR_AW-1:0] glyph_waddr;
    logic [CHAR_AW-1:0] glyph_raddr;
    logic [23:0]        glyph_wdata;

    // handshake
    logic               advance;
    logic               s_accept;
    logic               m_tvalid_reg;
    logic [111:0]       m_tdata_reg;
    logic               m_draw_reg;

    // datapath
    logic [4:0]         scale_eff;
    logic signed [5:0]  scale_s;
    logic [12:0]        begin13;
    logic [12:0]        w13;
    logic [11:0]        w_sat;
    logic               close_ok;
    logic               code_ok;
    logic               ch_ok;
    logic               ch_known;
    logic [11:0]        g_start;
    logic [11:0]        g_width;
    logic signed [13:0] gadv_base;
    logic signed [19:0] gadv;
    logic [12:0]        sp_adv;
    logic signed [9:0]  line_sum;
    logic signed [15:0] line_step;
    logic [16:0]        dw17;
    logic [12:0]        dh13;
    logic [8:0]         gc_ext;

    logic               draw;
    logic [11:0]        src_x, src_w, dest_h;
    logic signed [15:0] dest_x, dest_y;
    logic [15:0]        dest_w;

    // stream handshake: input register feeds the result register
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_color_reg     <= pgl_pkg::RST_SPLIT_COLOR;
            strip_height_reg    <= pgl_pkg::RST_STRIP_HEIGHT;
            space_size_reg      <= pgl_pkg::RST_SPACE_SIZE;
            letter_distance_reg <= pgl_pkg::RST_LETTER_DISTANCE;
            line_offset_reg     <= pgl_pkg::RST_LINE_OFFSET;
            scale_reg           <= pgl_pkg::RST_SCALE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pgl_pkg::CFG_SPLIT_COLOR:     split_color_reg     <= cfg_wdata;
                pgl_pkg::CFG_STRIP_HEIGHT:    strip_height_reg    <= cfg_wdata[7:0];
                pgl_pkg::CFG_SPACE_SIZE:      space_size_reg      <= cfg_wdata[7:0];
                pgl_pkg::CFG_LETTER_DISTANCE: letter_distance_reg <= cfg_wdata[7:0];
                pgl_pkg::CFG_LINE_OFFSET:     line_offset_reg     <= cfg_wdata[7:0];
                pgl_pkg::CFG_SCALE:           scale_reg           <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= s_tuser;
            ch_reg  <= s_tdata[7:0];
            pix_reg <= s_tdata[39:8];
            sx_reg  <= s_tdata[55:40];
            sy_reg  <= s_tdata[71:56];
        end
    end

    // name memory, read at the counter value that holds after this edge
    assign name_we_fire = advance && name_we;
    assign name_waddr   = name_count_reg[NAME_AW-1:0];
    assign gc_after     = advance ? glyph_counter_next : glyph_counter_reg;
    assign name_raddr   = gc_after[NAME_AW-1:0];

    always_ff @(posedge aclk) begin
        if (name_we_fire) begin
            name_mem[name_waddr] <= ch_reg;
        end
        nrd_reg       <= name_mem[name_raddr];
        nbyp_reg      <= name_we_fire && (name_waddr == name_raddr);
        nbyp_data_reg <= ch_reg;
    end

    assign name_code = nbyp_reg ? nbyp_data_reg : nrd_reg;

    // glyph table, read as an item is taken
    assign glyph_we_fire = advance && glyph_we;
    assign glyph_waddr   = name_code[CHAR_AW-1:0];
    assign glyph_raddr   = s_tdata[CHAR_AW-1:0];
    assign glyph_wdata   = {begin13[11:0], w_sat};

    always_ff @(posedge aclk) begin
        if (glyph_we_fire) begin
            glyph_mem[glyph_waddr] <= glyph_wdata;
        end
        if (s_accept) begin
            grd_reg       <= glyph_mem[glyph_raddr];
            gbyp_reg      <= glyph_we_fire && (glyph_waddr == glyph_raddr);
            gbyp_data_reg <= glyph_wdata;
        end
    end

    assign g_entry = gbyp_reg ? gbyp_data_reg : grd_reg;
    assign g_start = g_entry[23:12];
    assign g_width = g_entry[11:0];

    // effective scale clamped to 1..16
    always_comb begin
        priority if (scale_reg < pgl_pkg::SCALE_MIN) begin
            scale_eff = pgl_pkg::SCALE_MIN;
        end else if (scale_reg > pgl_pkg::SCALE_MAX) begin
            scale_eff = pgl_pkg::SCALE_MAX;
        end else begin
            scale_eff = scale_reg;
        end
    end
    assign scale_s = $signed({1'b0, scale_eff});

    // glyph slicing terms
    assign begin13  = 13'(glyph_begin_reg);
    assign w13      = 13'(scan_column_reg) - begin13;
    assign w_sat    = (w13 > 13'(pgl_pkg::WIDTH_MAX)) ? pgl_pkg::WIDTH_MAX : w13[11:0];
    assign close_ok = (scan_column_reg > glyph_begin_reg) &&
                      (glyph_counter_reg < name_count_reg);
    assign code_ok  = {1'b0, name_code} < 9'(CHAR_CODES);

    // pen advance terms
    assign ch_ok     = {1'b0, ch_reg} < 9'(CHAR_CODES);
    assign ch_known  = ch_ok && known_reg[ch_reg[CHAR_AW-1:0]];
    assign gadv_base = $signed({2'b00, g_width}) + 14'(letter_distance_reg);
    assign gadv      = 20'(gadv_base) * 20'(scale_s);
    assign sp_adv    = 13'(space_size_reg) * 13'(scale_eff);
    assign line_sum  = $signed({2'b00, strip_height_reg}) + 10'(line_offset_reg);
    assign line_step = 16'(line_sum) * 16'(scale_s);
    assign dw17      = 17'(g_width) * 17'(scale_eff);
    assign dh13      = 13'(strip_height_reg) * 13'(scale_eff);

    // single-pass item evaluation
    always_comb begin
        name_count_next    = name_count_reg;
        glyph_counter_next = glyph_counter_reg;
        scan_column_next   = scan_column_reg;
        glyph_begin_next   = glyph_begin_reg;
        pen_x_next         = pen_x_reg;
        pen_y_next         = pen_y_reg;
        name_we            = 1'b0;
        glyph_we           = 1'b0;
        draw               = 1'b0;
        src_x              = '0;
        src_w              = '0;
        dest_x             = '0;
        dest_y             = '0;
        dest_w             = '0;
        dest_h             = '0;
        unique case (op_reg)
            pgl_pkg::OP_LOAD_NAME: begin
                if (name_count_reg < NAME_CW'(MAX_NAMES)) begin
                    name_we         = 1'b1;
                    name_count_next = name_count_reg + 1'b1;
                end
            end
            pgl_pkg::OP_STRIP_PIXEL: begin
                if (scan_column_reg < COL_W'(STRIP_WIDTH)) begin
                    if (close_ok && (pix_reg == split_color_reg)) begin
                        glyph_we           = code_ok;
                        glyph_counter_next = glyph_counter_reg + 1'b1;
                        glyph_begin_next   = scan_column_reg + 1'b1;
                    end
                    scan_column_next = scan_column_reg + 1'b1;
                end
            end
            pgl_pkg::OP_STRIP_END: begin
                if (close_ok) begin
                    glyph_we           = code_ok;
                    glyph_counter_next = glyph_counter_reg + 1'b1;
                end
                scan_column_next = '0;
                glyph_begin_next = '0;
            end
            pgl_pkg::OP_TEXT_START: begin
                pen_x_next = sx_reg;
                pen_y_next = sy_reg;
            end
            pgl_pkg::OP_TEXT_CHAR: begin
                priority if (ch_reg == pgl_pkg::CHAR_NEWLINE) begin
                    pen_x_next = '0;
                    pen_y_next = pgl_pkg::sat16(24'(pen_y_reg) + 24'(line_step));
                end else if (ch_reg == pgl_pkg::CHAR_SPACE) begin
                    pen_x_next = pgl_pkg::sat16(24'(pen_x_reg) + $signed({11'd0, sp_adv}));
                end else if (ch_reg == pgl_pkg::CHAR_TAB) begin
                    pen_x_next = pgl_pkg::sat16(24'(pen_x_reg) +
                                                $signed({9'd0, sp_adv, 2'b00}));
                end else if (ch_known) begin
                    draw       = 1'b1;
                    src_x      = g_start;
                    src_w      = g_width;
                    dest_x     = pen_x_reg;
                    dest_y     = pen_y_reg;
                    dest_w     = dw17[16] ? 16'hffff : dw17[15:0];
                    dest_h     = dh13[11:0];
                    pen_x_next = pgl_pkg::sat16(24'(pen_x_reg) + 24'(gadv));
                end else begin
                    pen_x_next = pen_x_reg;
                end
            end
            default: ;
        endcase
    end

    // state update when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_count_reg    <= '0;
            glyph_counter_reg <= '0;
            scan_column_reg   <= '0;
            glyph_begin_reg   <= '0;
            known_reg         <= '0;
            pen_x_reg         <= '0;
            pen_y_reg         <= '0;
        end else if (advance) begin
            name_count_reg    <= name_count_next;
            glyph_counter_reg <= glyph_counter_next;
            scan_column_reg   <= scan_column_next;
            glyph_begin_reg   <= glyph_begin_next;
            pen_x_reg         <= pen_x_next;
            pen_y_reg         <= pen_y_next;
            if (glyph_we) begin
                known_reg[glyph_waddr] <= 1'b1;
            end
        end
    end

    // result register
    assign gc_ext = 9'(glyph_counter_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_draw_reg  <= draw;
            m_tdata_reg <= {4'd0, gc_ext[7:0], pen_x_next, dest_h, dest_w,
                            dest_y, dest_x, src_w, src_x};
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_draw_reg;

`ifndef SYNTHESIS
    a_glyphs_within_names: assert property (@(posedge aclk) disable iff (!aresetn)
        glyph_counter_reg <= name_count_reg)
        else $error("more glyphs sliced than names loaded");

    a_begin_within_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        glyph_begin_reg <= scan_column_reg)
        else $error("glyph start ahead of scan column");

    a_draw_has_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[23:12] != 12'd0))
        else $error("drawn glyph with zero width");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled while the pipeline can move");

    a_name_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        name_count_reg <= NAME_CW'(MAX_NAMES))
        else $error("name count beyond capacity");
`endif

endmodule

>>> verif/proportional_glyph_layout_tb.sv
module proportional_glyph_layout_tb;

    localparam int MAX_NAMES    = 128;
    localparam int STRIP_WIDTH  = 4096;
    localparam int CHAR_CODES   = 256;
    localparam int TAB_SPACES   = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int TEXT_ITEMS   = 100;

    // opcodes the block does not use
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // one input transaction, with an optional typed-in expectation
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [31:0] pix;
        logic [15:0] sx;
        logic [15:0] sy;
        logic        has_lit;
        logic [15:0] lit_pen_x;
        logic [7:0]  lit_glyphs;
    } stim_item_t;

    // one result transaction
    typedef struct packed {
        logic        draw;
        logic [11:0] src_x;
        logic [11:0] src_w;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [15:0] dest_w;
        logic [11:0] dest_h;
        logic [15:0] pen_x;
        logic [7:0]  glyphs_defined;
    } glyph_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = pgl_pkg::CFG_SPLIT_COLOR;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [0:0]   m_tuser;

    proportional_glyph_layout i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // layout engine shadow: configuration
    logic [31:0] split_color_q = pgl_pkg::RST_SPLIT_COLOR;
    int strip_h_q     = int'(pgl_pkg::RST_STRIP_HEIGHT);
    int space_q       = int'(pgl_pkg::RST_SPACE_SIZE);
    int letter_dist_q = int'($signed(pgl_pkg::RST_LETTER_DISTANCE));
    int line_off_q    = int'($signed(pgl_pkg::RST_LINE_OFFSET));
    int scale_q       = int'(pgl_pkg::RST_SCALE);

    // layout engine shadow: glyph table and pen
    int name_seq_q [MAX_NAMES];
    int name_cnt_q  = 0;
    int glyph_cnt_q = 0;
    int scan_col_q  = 0;
    int glyph_beg_q = 0;
    bit glyph_known_q [CHAR_CODES];
    int glyph_start_q [CHAR_CODES];
    int glyph_width_q [CHAR_CODES];
    logic signed [15:0] pen_x_q = '0;
    logic signed [15:0] pen_y_q = '0;

    glyph_result_t pending_layouts [$];
    stim_item_t    directed_rows [$];
    int mismatch_count = 0;
    int feed_gap_pct   = 0;
    int sink_stall_pct = 0;

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'h7fff;
        end else if (v < -32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // end the current glyph at column col and file it under the next name
    function automatic void close_glyph(input int col);
        int w;
        int code;
        if (col <= glyph_beg_q || glyph_cnt_q >= name_cnt_q || glyph_cnt_q >= MAX_NAMES) begin
            return;
        end
        code = name_seq_q[glyph_cnt_q];
        w = col - glyph_beg_q;
        if (w > int'(pgl_pkg::WIDTH_MAX)) begin
            w = int'(pgl_pkg::WIDTH_MAX);
        end
        glyph_known_q[code] = 1'b1;
        glyph_start_q[code] = glyph_beg_q & 32'hfff;
        glyph_width_q[code] = w;
        glyph_cnt_q++;
        glyph_beg_q = col + 1;
    endfunction

    // advance the shadow engine by one transaction and return its result
    function automatic glyph_result_t predict_layout(input stim_item_t it);
        glyph_result_t r;
        longint mag;
        longint gw;
        r = '0;
        if (scale_q < int'(pgl_pkg::SCALE_MIN)) begin
            mag = longint'(pgl_pkg::SCALE_MIN);
        end else if (scale_q > int'(pgl_pkg::SCALE_MAX)) begin
            mag = longint'(pgl_pkg::SCALE_MAX);
        end else begin
            mag = scale_q;
        end
        case (it.op)
            pgl_pkg::OP_LOAD_NAME: begin
                if (name_cnt_q < MAX_NAMES) begin
                    name_seq_q[name_cnt_q] = int'(it.ch);
                    name_cnt_q++;
                end
            end
            pgl_pkg::OP_STRIP_PIXEL: begin
                if (scan_col_q < STRIP_WIDTH) begin
                    if (scan_col_q > glyph_beg_q && it.pix == split_color_q) begin
                        close_glyph(scan_col_q);
                    end
                    scan_col_q++;
                end
            end
            pgl_pkg::OP_STRIP_END: begin
                close_glyph(scan_col_q);
                scan_col_q = 0;
                glyph_beg_q = 0;
            end
            pgl_pkg::OP_TEXT_START: begin
                pen_x_q = it.sx;
                pen_y_q = it.sy;
            end
            pgl_pkg::OP_TEXT_CHAR: begin
                if (it.ch == pgl_pkg::CHAR_NEWLINE) begin
                    pen_x_q = '0;
                    pen_y_q = clamp16(longint'(pen_y_q) +
                        (longint'(strip_h_q) + longint'(line_off_q)) * mag);
                end else if (it.ch == pgl_pkg::CHAR_SPACE) begin
                    pen_x_q = clamp16(longint'(pen_x_q) + longint'(space_q) * mag);
                end else if (it.ch == pgl_pkg::CHAR_TAB) begin
                    pen_x_q = clamp16(longint'(pen_x_q) +
                        longint'(space_q) * TAB_SPACES * mag);
                end else if (glyph_known_q[it.ch]) begin
                    gw = longint'(glyph_width_q[it.ch]) * mag;
                    r.draw   = 1'b1;
                    r.src_x  = 12'(glyph_start_q[it.ch]);
                    r.src_w  = 12'(glyph_width_q[it.ch]);
                    r.dest_x = pen_x_q;
                    r.dest_y = pen_y_q;
                    r.dest_w = (gw > 65535) ? 16'hffff : 16'(gw);
                    r.dest_h = 12'(longint'(strip_h_q) * mag);
                    pen_x_q = clamp16(longint'(pen_x_q) +
                        (longint'(glyph_width_q[it.ch]) + longint'(letter_dist_q)) * mag);
                end
            end
            default: ;
        endcase
        r.pen_x = pen_x_q;
        r.glyphs_defined = glyph_cnt_q[7:0];
        return r;
    endfunction

    function automatic stim_item_t mk_item(input logic [2:0] op, input logic [7:0] ch);
        stim_item_t it;
        it = '0;
        it.op  = op;
        it.ch  = ch;
        it.pix = $urandom;
        it.sx  = 16'($urandom);
        it.sy  = 16'($urandom);
        return it;
    endfunction

    function automatic void add_row(input logic [2:0] op, input logic [7:0] ch,
                                    input logic [31:0] pix, input logic [15:0] sx,
                                    input logic [15:0] sy, input logic has_lit,
                                    input logic [15:0] lit_pen_x, input logic [7:0] lit_glyphs);
        stim_item_t it;
        it = '{op, ch, pix, sx, sy, has_lit, lit_pen_x, lit_glyphs};
        directed_rows.push_back(it);
    endfunction

    // drive one transaction, with random gaps before it
    task automatic send_item(input stim_item_t it);
        glyph_result_t want;
        while ($urandom_range(99) < feed_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.sy, it.sx, it.pix, it.ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_layout(it);
        if (it.has_lit) begin
            want = '0;
            want.pen_x = it.lit_pen_x;
            want.glyphs_defined = it.lit_glyphs;
        end
        pending_layouts.push_back(want);
        @(negedge aclk);
    endtask

    task automatic send_pixel(input logic is_split);
        stim_item_t it;
        it = mk_item(pgl_pkg::OP_STRIP_PIXEL, 8'($urandom));
        if (is_split) begin
            it.pix = split_color_q;
        end else if (it.pix == split_color_q) begin
            it.pix = ~it.pix;
        end
        send_item(it);
    endtask

    // one strip row: glyph bodies, splits, skipped pixels, then the row end
    task automatic send_strip_row(input int n_glyphs);
        int w;
        for (int g = 0; g < n_glyphs; g++) begin
            w = $urandom_range(6, 0);
            repeat (w) send_pixel(1'b0);
            send_pixel(1'b1);
            send_pixel($urandom_range(9) < 3);
        end
        repeat ($urandom_range(3, 0)) send_pixel(1'b0);
        send_item(mk_item(pgl_pkg::OP_STRIP_END, 8'($urandom)));
    endtask

    // mostly text, with a little of everything else mixed in
    task automatic send_text_item();
        stim_item_t it;
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            it = mk_item(pgl_pkg::OP_TEXT_START, 8'($urandom));
        end else if (r < 12) begin
            it = mk_item(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_NEWLINE);
        end else if (r < 18) begin
            it = mk_item(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_SPACE);
        end else if (r < 22) begin
            it = mk_item(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_TAB);
        end else if (r < 75) begin
            it = mk_item(pgl_pkg::OP_TEXT_CHAR,
                         8'(name_seq_q[$urandom_range(name_cnt_q - 1)]));
        end else if (r < 85) begin
            it = mk_item(pgl_pkg::OP_TEXT_CHAR, 8'($urandom));
        end else if (r < 90) begin
            it = mk_item(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)), 8'($urandom));
        end else if (r < 94) begin
            it = mk_item(pgl_pkg::OP_LOAD_NAME, 8'($urandom));
        end else if (r < 98) begin
            it = mk_item(pgl_pkg::OP_STRIP_PIXEL, 8'($urandom));
        end else begin
            it = mk_item(pgl_pkg::OP_STRIP_END, 8'($urandom));
        end
        send_item(it);
    endtask

    task automatic write_reg(input pgl_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pgl_pkg::CFG_SPLIT_COLOR:     split_color_q = val;
            pgl_pkg::CFG_STRIP_HEIGHT:    strip_h_q = int'(val[7:0]);
            pgl_pkg::CFG_SPACE_SIZE:      space_q = int'(val[7:0]);
            pgl_pkg::CFG_LETTER_DISTANCE: letter_dist_q = int'($signed(val[7:0]));
            pgl_pkg::CFG_LINE_OFFSET:     line_off_q = int'($signed(val[7:0]));
            pgl_pkg::CFG_SCALE:           scale_q = int'(val[4:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // wait until every result is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_layouts.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // register settings for the text phases, extremes first
    task automatic apply_setting(input int k);
        case (k)
            0: begin
                write_reg(pgl_pkg::CFG_SCALE, 32'd0);
                write_reg(pgl_pkg::CFG_STRIP_HEIGHT, 32'd1);
                write_reg(pgl_pkg::CFG_SPACE_SIZE, 32'd0);
                write_reg(pgl_pkg::CFG_LETTER_DISTANCE, 32'h80);
                write_reg(pgl_pkg::CFG_LINE_OFFSET, 32'h80);
            end
            1: begin
                write_reg(pgl_pkg::CFG_SCALE, 32'd16);
                write_reg(pgl_pkg::CFG_STRIP_HEIGHT, 32'd255);
                write_reg(pgl_pkg::CFG_SPACE_SIZE, 32'd255);
                write_reg(pgl_pkg::CFG_LETTER_DISTANCE, 32'h7f);
                write_reg(pgl_pkg::CFG_LINE_OFFSET, 32'h7f);
            end
            2: begin
                write_reg(pgl_pkg::CFG_SCALE, 32'd31);
                write_reg(pgl_pkg::CFG_STRIP_HEIGHT, $urandom_range(255, 1));
                write_reg(pgl_pkg::CFG_SPACE_SIZE, $urandom_range(255));
                write_reg(pgl_pkg::CFG_LETTER_DISTANCE, $urandom_range(255));
                write_reg(pgl_pkg::CFG_LINE_OFFSET, $urandom_range(255));
                write_reg(pgl_pkg::CFG_SPLIT_COLOR, $urandom);
            end
            3: begin
                write_reg(pgl_pkg::CFG_SCALE, $urandom_range(16, 1));
                write_reg(pgl_pkg::CFG_STRIP_HEIGHT, $urandom_range(255, 1));
                write_reg(pgl_pkg::CFG_SPACE_SIZE, $urandom_range(255));
                write_reg(pgl_pkg::CFG_LETTER_DISTANCE, $urandom_range(255));
                write_reg(pgl_pkg::CFG_LINE_OFFSET, $urandom_range(255));
            end
            default: begin
                write_reg(pgl_pkg::CFG_SCALE, 32'(pgl_pkg::RST_SCALE));
                write_reg(pgl_pkg::CFG_STRIP_HEIGHT, 32'(pgl_pkg::RST_STRIP_HEIGHT));
                write_reg(pgl_pkg::CFG_SPACE_SIZE, 32'(pgl_pkg::RST_SPACE_SIZE));
                write_reg(pgl_pkg::CFG_LETTER_DISTANCE, 32'(pgl_pkg::RST_LETTER_DISTANCE));
                write_reg(pgl_pkg::CFG_LINE_OFFSET, 32'(pgl_pkg::RST_LINE_OFFSET));
            end
        endcase
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", fname, want, got);
            mismatch_count++;
        end
    endtask

    // compare one result transaction with the oldest expectation
    task automatic take_result();
        glyph_result_t got;
        glyph_result_t want;
        got.draw           = m_tuser[0];
        got.src_x          = m_tdata[11:0];
        got.src_w          = m_tdata[23:12];
        got.dest_x         = m_tdata[39:24];
        got.dest_y         = m_tdata[55:40];
        got.dest_w         = m_tdata[71:56];
        got.dest_h         = m_tdata[83:72];
        got.pen_x          = m_tdata[99:84];
        got.glyphs_defined = m_tdata[107:100];
        if (pending_layouts.size() == 0) begin
            $error("result transaction with no expectation waiting");
            mismatch_count++;
        end else begin
            want = pending_layouts.pop_front();
            check_field("draw", want.draw, got.draw);
            check_field("src_x", want.src_x, got.src_x);
            check_field("src_w", want.src_w, got.src_w);
            check_field("dest_x", want.dest_x, got.dest_x);
            check_field("dest_y", want.dest_y, got.dest_y);
            check_field("dest_w", want.dest_w, got.dest_w);
            check_field("dest_h", want.dest_h, got.dest_h);
            check_field("pen_x", want.pen_x, got.pen_x);
            check_field("glyphs_defined", want.glyphs_defined, got.glyphs_defined);
        end
    endtask

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            take_result();
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("proportional_glyph_layout test failed");
        $finish;
    end

    // stimulus
    initial begin
        stim_item_t it;
        logic split_moved;
        split_moved = 1'b0;

        // text before setup, unused opcode, then a tiny font and some text
        add_row(pgl_pkg::OP_TEXT_CHAR, 8'h41, 32'h0, 16'h0, 16'h0, 1'b1, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_SPACE, 32'h0, 16'h0, 16'h0,
                1'b1, 16'd4, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_TAB, 32'h0, 16'h0, 16'h0,
                1'b1, 16'd20, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_NEWLINE, 32'h0, 16'h0, 16'h0,
                1'b1, 16'd0, 8'd0);
        add_row(OP_UNUSED_LAST, 8'hff, 32'hffffffff, 16'hffff, 16'hffff, 1'b1, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_LOAD_NAME, 8'h41, 32'h0, 16'h0, 16'h0, 1'b1, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_LOAD_NAME, 8'h42, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_LOAD_NAME, 8'hff, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_LOAD_NAME, 8'h00, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'hffffffff, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'h12345678, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'hffffffff, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_PIXEL, 8'h0, 32'haaaaaaaa, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_STRIP_END, 8'h0, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_START, 8'h0, 32'h0, 16'h7fff, 16'h8000, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, 8'h41, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_START, 8'h0, 32'h0, 16'h8000, 16'h7fff, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, 8'hff, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, pgl_pkg::CHAR_NEWLINE, 32'h0, 16'h0, 16'h0,
                1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, 8'h42, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);
        add_row(pgl_pkg::OP_TEXT_CHAR, 8'h00, 32'h0, 16'h0, 16'h0, 1'b0, 16'd0, 8'd0);

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        feed_gap_pct   = 13;
        sink_stall_pct = 45;
        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // more names than the table holds, control codes among them
        repeat (130) begin
            it = mk_item(pgl_pkg::OP_LOAD_NAME, 8'($urandom));
            case ($urandom_range(19))
                0: it.ch = pgl_pkg::CHAR_NEWLINE;
                1: it.ch = pgl_pkg::CHAR_SPACE;
                2: it.ch = pgl_pkg::CHAR_TAB;
                default: ;
            endcase
            send_item(it);
        end

        // slice the font, then one row after the names run out
        drain();
        write_reg(pgl_pkg::CFG_SPLIT_COLOR, $urandom);
        while (glyph_cnt_q < name_cnt_q) begin
            if (!split_moved && glyph_cnt_q >= MAX_NAMES / 2) begin
                drain();
                write_reg(pgl_pkg::CFG_SPLIT_COLOR, 32'hffffffff);
                split_moved = 1'b1;
            end
            send_strip_row($urandom_range(12, 1));
        end
        send_strip_row($urandom_range(6, 1));

        // text under several register settings
        feed_gap_pct   = 45;
        sink_stall_pct = 13;
        for (int k = 0; k < 5; k++) begin
            if (k == 3) begin
                feed_gap_pct   = 0;
                sink_stall_pct = 0;
            end
            drain();
            apply_setting(k);
            repeat (TEXT_ITEMS) send_text_item();
        end

        drain();
        if (mismatch_count == 0) begin
            $display("proportional_glyph_layout test passed");
        end else begin
            $display("proportional_glyph_layout test failed");
        end
        $finish;
    end

endmodule
